// ===== rtl/sev_pkg.sv =====
// Shared constants, types and helpers for the sliding energy variance block.
package sev_pkg;

  localparam int unsigned DEF_WINDOW      = 256;
  localparam int unsigned DEF_SAMPLE_BITS = 12;
  localparam int unsigned FIELD_W         = 12;
  localparam int unsigned VAR_W           = 45;

  localparam int unsigned MQ_DEPTH = 4;
  localparam int unsigned MQ_PTR_W = $clog2(MQ_DEPTH);
  localparam int unsigned MQ_CNT_W = $clog2(MQ_DEPTH + 1);

  typedef struct packed {
    logic                empty;
    logic [MQ_CNT_W-1:0] used;
  } mq_status_t;

  // energy, energy^2, old energy, old energy^2, result flag, delayed I and Q
  function automatic int unsigned entry_width(input int unsigned sample_bits);
    return 14 * sample_bits - 1;
  endfunction

endpackage

// ===== rtl/sev_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
module sev_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sev_fifo.sv =====
// Short queue between the front and back parts.
module sev_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    data_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    data_o,
  output sev_pkg::mq_status_t status_o
);

  import sev_pkg::*;

  logic [WIDTH-1:0]    mem_q [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] head_q, head_d;
  logic [MQ_PTR_W-1:0] tail_q, tail_d;
  logic [MQ_CNT_W-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d = MQ_PTR_W'(tail_q + 1'b1);
    end
    if (pop_i) begin
      head_d = MQ_PTR_W'(head_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = MQ_CNT_W'(count_q + 1'b1);
    end else if (!push_i && pop_i) begin
      count_d = MQ_CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= data_i;
    end
  end

  assign data_o         = mem_q[head_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.used  = count_q;

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue popped while empty");

endmodule

// ===== rtl/sev_front.sv =====
// Front part: takes samples, forms energies, keeps the window memory and fill state.
module sev_front #(
  parameter int unsigned WINDOW      = sev_pkg::DEF_WINDOW,
  parameter int unsigned SAMPLE_BITS = sev_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned ENTRY_W     = sev_pkg::entry_width(SAMPLE_BITS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [sev_pkg::FIELD_W-1:0]   sample_i_i,
  input  logic [sev_pkg::FIELD_W-1:0]   sample_q_i,
  input  sev_pkg::mq_status_t           mq_status_i,
  output logic                          mq_push_o,
  output logic [ENTRY_W-1:0]            mq_entry_o
);

  import sev_pkg::*;

  localparam int unsigned ADDR_W = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned E_W    = 2 * SAMPLE_BITS;
  localparam int unsigned ESQ_W  = 4 * SAMPLE_BITS - 1;
  localparam int unsigned RAM_W  = 2 * SAMPLE_BITS + E_W;
  localparam int unsigned CW     = MQ_CNT_W + 1;

  typedef struct packed {
    logic [E_W-1:0]         energy;
    logic [ESQ_W-1:0]       energy_sq;
    logic [E_W-1:0]         old_energy;
    logic [ESQ_W-1:0]       old_energy_sq;
    logic                   has_result;
    logic [SAMPLE_BITS-1:0] dly_i;
    logic [SAMPLE_BITS-1:0] dly_q;
  } entry_t;

  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] in_i, in_q;
  logic signed [E_W-1:0]         pow_i, pow_q;
  logic [E_W-1:0]                energy;
  logic [CW-1:0]                 inflight;

  logic [ADDR_W-1:0] wp_q;
  logic [FILL_W-1:0] fill_q;
  logic              a_valid_q, a_rm_q, a_res_q;
  logic [E_W-1:0]    a_energy_q;
  logic [E_W-1:0]    last_energy_q;
  logic              b_valid_q;
  entry_t            b_entry_q, b_entry_d;

  logic [RAM_W-1:0]   ram_rdata;
  logic [2*E_W-1:0]   new_sq_full, old_sq_full;
  logic [E_W-1:0]     old_energy;

  assign inflight = CW'(mq_status_i.used) + CW'(a_valid_q) + CW'(b_valid_q);
  assign full     = (inflight >= CW'(MQ_DEPTH));
  assign accept   = push && !full;

  assign in_i   = sample_i_i[SAMPLE_BITS-1:0];
  assign in_q   = sample_q_i[SAMPLE_BITS-1:0];
  assign pow_i  = in_i * in_i;
  assign pow_q  = in_q * in_q;
  assign energy = E_W'($unsigned(pow_i)) + E_W'($unsigned(pow_q));

  sev_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i ({in_i, in_q, energy}),
    .re_i    (accept),
    .raddr_i (ADDR_W'(wp_q + 1'b1)),
    .rdata_o (ram_rdata)
  );

  // Sample read back one slot ahead is the oldest one; it leaves with the next beat.
  assign old_energy  = a_rm_q ? last_energy_q : '0;
  assign new_sq_full = a_energy_q * a_energy_q;
  assign old_sq_full = old_energy * old_energy;

  always_comb begin
    b_entry_d.energy        = a_energy_q;
    b_entry_d.energy_sq     = ESQ_W'(new_sq_full);
    b_entry_d.old_energy    = old_energy;
    b_entry_d.old_energy_sq = ESQ_W'(old_sq_full);
    b_entry_d.has_result    = a_res_q;
    b_entry_d.dly_i         = ram_rdata[RAM_W-1 -: SAMPLE_BITS];
    b_entry_d.dly_q         = ram_rdata[E_W+SAMPLE_BITS-1 -: SAMPLE_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      fill_q    <= '0;
      a_valid_q <= 1'b0;
      a_rm_q    <= 1'b0;
      a_res_q   <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
      b_valid_q <= a_valid_q;
      if (accept) begin
        wp_q    <= ADDR_W'(wp_q + 1'b1);
        a_rm_q  <= (fill_q == FILL_W'(WINDOW));
        a_res_q <= (fill_q >= FILL_W'(WINDOW - 1));
        if (fill_q != FILL_W'(WINDOW)) begin
          fill_q <= FILL_W'(fill_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_energy_q <= energy;
    end
    if (a_valid_q) begin
      last_energy_q <= ram_rdata[E_W-1:0];
      b_entry_q     <= b_entry_d;
    end
  end

  assign mq_push_o  = b_valid_q;
  assign mq_entry_o = b_entry_q;

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (CW'(mq_status_i.used) < CW'(MQ_DEPTH)))
    else $error("front pushed into a full queue");

  a_rm_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_rm_q) |-> a_res_q)
    else $error("sample removal without a result");

endmodule

// ===== rtl/sev_back.sv =====
// Back part: running sums, variance arithmetic and the result register.
module sev_back #(
  parameter int unsigned WINDOW      = sev_pkg::DEF_WINDOW,
  parameter int unsigned SAMPLE_BITS = sev_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned ENTRY_W     = sev_pkg::entry_width(SAMPLE_BITS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sev_pkg::mq_status_t         mq_status_i,
  input  logic [ENTRY_W-1:0]          mq_entry_i,
  output logic                        mq_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [sev_pkg::FIELD_W-1:0] delayed_i_o,
  output logic [sev_pkg::FIELD_W-1:0] delayed_q_o,
  output logic [sev_pkg::VAR_W-1:0]   energy_variance_o
);

  import sev_pkg::*;

  localparam int unsigned LOG_W  = $clog2(WINDOW);
  localparam int unsigned E_W    = 2 * SAMPLE_BITS;
  localparam int unsigned ESQ_W  = 4 * SAMPLE_BITS - 1;
  localparam int unsigned SUM_W  = 2 * SAMPLE_BITS + LOG_W;
  localparam int unsigned SQ_W   = 4 * SAMPLE_BITS - 1 + LOG_W;
  localparam int unsigned DIFF_W = 2 * SUM_W;
  localparam int unsigned SH     = 2 * LOG_W;
  localparam int unsigned VW     = (DIFF_W > VAR_W) ? DIFF_W : VAR_W;

  typedef struct packed {
    logic [E_W-1:0]         energy;
    logic [ESQ_W-1:0]       energy_sq;
    logic [E_W-1:0]         old_energy;
    logic [ESQ_W-1:0]       old_energy_sq;
    logic                   has_result;
    logic [SAMPLE_BITS-1:0] dly_i;
    logic [SAMPLE_BITS-1:0] dly_q;
  } entry_t;

  entry_t ent;
  logic   adv, take;

  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SQ_W-1:0]        sq_q, sq_d;
  logic                   s1_valid_q, s1_res_q;
  logic [SAMPLE_BITS-1:0] s1_di_q, s1_dq_q;

  logic                   s2_valid_q;
  logic [DIFF_W-1:0]      s2_a_q, s2_b_q;
  logic [DIFF_W-1:0]      a_d, b_d;
  logic [SAMPLE_BITS-1:0] s2_di_q, s2_dq_q;

  logic                   out_valid_q;
  logic [VAR_W-1:0]       out_var_q;
  logic [SAMPLE_BITS-1:0] out_di_q, out_dq_q;

  logic [DIFF_W-1:0]      diff;
  logic [VW-1:0]          var_ext;

  assign ent      = entry_t'(mq_entry_i);
  assign adv      = !out_valid_q || pop;
  assign take     = adv && !mq_status_i.empty;
  assign mq_pop_o = take;

  assign sum_d = sum_q + SUM_W'(ent.energy) - SUM_W'(ent.old_energy);
  assign sq_d  = sq_q + SQ_W'(ent.energy_sq) - SQ_W'(ent.old_energy_sq);

  // window scaling is a shift: WINDOW must be a power of two, and the block does not check it
  assign a_d = DIFF_W'(sq_q) << LOG_W;
  assign b_d = sum_q * sum_q;

  assign diff    = (s2_a_q >= s2_b_q) ? (s2_a_q - s2_b_q) : '0;
  assign var_ext = VW'(diff) >> SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sq_q        <= '0;
      s1_valid_q  <= 1'b0;
      s1_res_q    <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= take;
      s2_valid_q  <= s1_valid_q && s1_res_q;
      out_valid_q <= s2_valid_q;
      if (take) begin
        sum_q    <= sum_d;
        sq_q     <= sq_d;
        s1_res_q <= ent.has_result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (take) begin
        s1_di_q <= ent.dly_i;
        s1_dq_q <= ent.dly_q;
      end
      s2_a_q    <= a_d;
      s2_b_q    <= b_d;
      s2_di_q   <= s1_di_q;
      s2_dq_q   <= s1_dq_q;
      out_var_q <= var_ext[VAR_W-1:0];
      out_di_q  <= s2_di_q;
      out_dq_q  <= s2_dq_q;
    end
  end

  assign empty             = !out_valid_q;
  assign delayed_i_o       = FIELD_W'(signed'(out_di_q));
  assign delayed_q_o       = FIELD_W'(signed'(out_dq_q));
  assign energy_variance_o = out_var_q;

  a_sums_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_q == '0) |-> (sq_q == '0))
    else $error("energy sums disagree");

  a_diff_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_a_q >= s2_b_q))
    else $error("negative variance numerator");

endmodule

// ===== rtl/sliding_energy_variance.sv =====
// Top level: sliding-window variance of complex sample energy.
//
//   channel  | handshake    | beat
//   ---------+--------------+-----------------------------------------------
//   sample   | push / full  | sample_i_i, sample_q_i
//   result   | pop / empty  | delayed_i_o, delayed_q_o, energy_variance_o
//
// One sample per clock while full is low; a result passes stages a, b, the queue, s1, s2 and out.
// The window memory takes one write and one read per beat; the 32x32 square
// of the energy sum is the widest stage.
// full rises when the front stages and the four-entry queue hold four beats.
// A held result stalls only the back part until the front runs out of room.
// Reset clears fill state and sums; the window memory needs no clearing pass.
module sliding_energy_variance #(
  parameter int unsigned WINDOW      = sev_pkg::DEF_WINDOW,
  parameter int unsigned SAMPLE_BITS = sev_pkg::DEF_SAMPLE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [sev_pkg::FIELD_W-1:0] sample_i_i,
  input  logic [sev_pkg::FIELD_W-1:0] sample_q_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [sev_pkg::FIELD_W-1:0] delayed_i_o,
  output logic [sev_pkg::FIELD_W-1:0] delayed_q_o,
  output logic [sev_pkg::VAR_W-1:0]   energy_variance_o
);

  import sev_pkg::*;

  localparam int unsigned ENTRY_W = entry_width(SAMPLE_BITS);

  mq_status_t         mq_status;
  logic               mq_push, mq_pop;
  logic [ENTRY_W-1:0] mq_wdata, mq_rdata;

  sev_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .sample_i_i  (sample_i_i),
    .sample_q_i  (sample_q_i),
    .mq_status_i (mq_status),
    .mq_push_o   (mq_push),
    .mq_entry_o  (mq_wdata)
  );

  sev_fifo #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (mq_push),
    .data_i   (mq_wdata),
    .pop_i    (mq_pop),
    .data_o   (mq_rdata),
    .status_o (mq_status)
  );

  sev_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mq_status_i       (mq_status),
    .mq_entry_i        (mq_rdata),
    .mq_pop_o          (mq_pop),
    .empty             (empty),
    .pop               (pop),
    .delayed_i_o       (delayed_i_o),
    .delayed_q_o       (delayed_q_o),
    .energy_variance_o (energy_variance_o)
  );

endmodule
